// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the panel formatter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge outside reset.
`define SSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SSP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/ssp_pkg.sv =====
// Package of the seven-segment panel formatter: opcodes, FSM state type,
// status struct, frame constants and the brightness tables. No dependencies.
package ssp_pkg;

    localparam int NUM_DIGITS = 4;

    // Request opcodes
    localparam logic [3:0] OP_MAP_WRITE  = 4'd0;
    localparam logic [3:0] OP_TEXT_START = 4'd1;
    localparam logic [3:0] OP_TEXT_CHAR  = 4'd2;
    localparam logic [3:0] OP_TEXT_END   = 4'd3;
    localparam logic [3:0] OP_DIGIT      = 4'd4;
    localparam logic [3:0] OP_DOTS       = 4'd5;
    localparam logic [3:0] OP_LED        = 4'd6;
    localparam logic [3:0] OP_BRIGHTNESS = 4'd7;
    localparam logic [3:0] OP_RAW        = 4'd8;

    // Frame bytes and masks
    localparam logic [7:0] ADDR_CMD     = 8'hC0;
    localparam logic [7:0] LED_CMD      = 8'hC8;
    localparam logic [7:0] SEG_MASK     = 8'h7F;
    localparam logic [2:0] TEXT_POS_MAX = 3'd5;
    localparam logic [2:0] DISP_LAST    = 3'd7;
    localparam logic [2:0] LED_LAST     = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DISP,
        ST_LED,
        ST_ONE
    } state_t;

    typedef struct packed {
        state_t     state;
        logic [2:0] text_pos;
        logic [2:0] cnt;
        logic       load;
    } status_t;

    // Permute segments for a panel rotated 180 degrees
    function automatic logic [7:0] rotate_segments(input logic [7:0] s);
        return {1'b0, s[6], s[2:0], s[5:3]};
    endfunction

    // Round a clamped brightness request to a supported level
    function automatic logic [3:0] level_round(input logic [3:0] b);
        logic [3:0] r;
        case (b)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd1;
            4'd2:    r = 4'd2;
            4'd3, 4'd4, 4'd5, 4'd6: r = 4'd4;
            4'd7, 4'd8, 4'd9, 4'd10: r = 4'd10;
            4'd11:   r = 4'd11;
            4'd12:   r = 4'd12;
            4'd13:   r = 4'd13;
            default: r = 4'd14;
        endcase
        return r;
    endfunction

    // Command byte for a rounded brightness level
    function automatic logic [7:0] level_cmd(input logic [3:0] l);
        logic [7:0] c;
        case (l)
            4'd0:    c = 8'h80;
            4'd1:    c = 8'h88;
            4'd2:    c = 8'h89;
            4'd4:    c = 8'h8A;
            4'd10:   c = 8'h8B;
            4'd11:   c = 8'h8C;
            4'd12:   c = 8'h8D;
            4'd13:   c = 8'h8E;
            4'd14:   c = 8'h8F;
            4'd15:   c = 8'h00;
            default: c = 8'hC0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/seven_segment_panel_formatter.sv =====
// Top level of the seven-segment panel formatter: stream ports, the
// character map RAM and the control core. Depends on ssp_pkg, ssp_ram,
// ssp_core and assert_macros.svh.
//
// One request enters at a time. Map writes, text start, ignored requests and
// skipped text characters leave the core in its idle state. A text character
// that goes through the map passes through the lookup state (one read of the
// character map RAM, whose read data is registered). A display update sends 8
// bytes, an LED update 2 and a brightness or raw byte 1, since the output
// byte register moves one byte per cycle while the sink is ready; stalls on
// the output side hold the frame back. The next request is taken as soon as the
// final byte of a frame sits in the output register.
`include "assert_macros.svh"

module seven_segment_panel_formatter (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: upside_down
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // op[3:0], index[10:4], value[18:11], zero[23:19]
    input  logic        s_tlast,  // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // out_byte[7:0], level_now[11:8], zero[15:12]
    output logic        m_tlast   // frame_end
);

    logic             upside_down_reg;
    logic [3:0]       op;
    logic [6:0]       index;
    logic [7:0]       value;
    logic             map_we;
    logic [7:0]       map_data;
    logic [7:0]       out_byte;
    logic [3:0]       level_now;
    ssp_pkg::status_t status;

    assign op    = s_tdata[3:0];
    assign index = s_tdata[10:4];
    assign value = s_tdata[18:11];

    // Hold the orientation register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upside_down_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            upside_down_reg <= cfg_wdata;
        end
    end

    // Write the map on a map write request; read at the character code
    assign map_we = s_tvalid && s_tready && (op == ssp_pkg::OP_MAP_WRITE);

    ssp_ram #(
        .WIDTH (8),
        .DEPTH (128)
    ) u_char_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (index),
        .wdata (value),
        .raddr (value[6:0]),
        .rdata (map_data)
    );

    ssp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .upside_down (upside_down_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .op          (op),
        .index       (index),
        .value       (value),
        .last        (s_tlast),
        .map_data    (map_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_byte    (out_byte),
        .frame_end   (m_tlast),
        .level_now   (level_now),
        .status      (status)
    );

    assign m_tdata = {4'd0, level_now, out_byte};

    `SSP_ASSERT(a_lookup_one_cycle, clk, rst_n, status.state == ssp_pkg::ST_LOOKUP |=> status.state == ssp_pkg::ST_IDLE, "text lookup did not finish in one cycle")
    `SSP_ASSERT_NEVER(a_text_pos_range, clk, rst_n, status.text_pos > ssp_pkg::TEXT_POS_MAX, "text position past its limit")
    `SSP_ASSERT(a_disp_end, clk, rst_n, status.load && status.state == ssp_pkg::ST_DISP && status.cnt == ssp_pkg::DISP_LAST |=> m_tvalid && m_tlast, "display frame did not close on its eighth byte")
    `SSP_ASSERT_NEVER(a_no_overwrite, clk, rst_n, m_tvalid && !m_tready && status.load, "output byte overwritten while stalled")

endmodule

// ===== rtl/core/ssp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/ssp_core.sv =====
// Control and panel state of the formatter: request decode, text lookup
// through the character map, frame sequencing and the output byte register.
// Depends on ssp_pkg; the character map RAM sits in the top level.
module ssp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                upside_down,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [3:0]          op,
    input  logic [6:0]          index,
    input  logic [7:0]          value,
    input  logic                last,
    input  logic [7:0]          map_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          out_byte,
    output logic                frame_end,
    output logic [3:0]          level_now,
    output ssp_pkg::status_t    status
);

    ssp_pkg::state_t state_reg, state_next;

    logic [7:0] digit_reg [ssp_pkg::NUM_DIGITS];
    logic [3:0] dot_reg;
    logic [1:0] led_reg;
    logic [3:0] bright_reg;
    logic [2:0] pos_reg;
    logic       lwd_reg;
    logic [2:0] cnt_reg;
    logic [7:0] one_byte_reg;
    logic       one_last_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic [3:0] level_reg;

    logic       accept;
    logic       out_free;
    logic       load;
    logic [7:0] load_byte;
    logic       load_last;
    logic [7:0] disp_byte;
    logic [1:0] disp_idx;
    logic [7:0] led_byte;
    logic       is_dot;
    logic [2:0] dot_pos;
    logic [3:0] bright_clamp;
    logic [3:0] bright_round;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !valid_reg || m_tready;

    // Byte of the display frame at the current slot
    always_comb
    begin
        disp_idx  = upside_down ? cnt_reg[2:1] : ~cnt_reg[2:1];
        disp_byte = 8'h00;
        if (cnt_reg == 3'd0)
        begin
            disp_byte = ssp_pkg::ADDR_CMD;
        end
        else if (cnt_reg[0])
        begin
            disp_byte = upside_down ? ssp_pkg::rotate_segments(digit_reg[disp_idx])
                                    : (digit_reg[disp_idx] & ssp_pkg::SEG_MASK);
            disp_byte[7] = dot_reg[disp_idx];
        end
    end

    // LED byte: bits swap unless the panel is rotated
    assign led_byte = upside_down ? {6'd0, led_reg} : {6'd0, led_reg[0], led_reg[1]};

    // Text decode of the mapped symbol
    assign is_dot  = !upside_down && map_data[7];
    assign dot_pos = (!lwd_reg && pos_reg != 3'd0) ? pos_reg - 3'd1 : pos_reg;

    // Brightness clamp and rounding
    assign bright_clamp = (value > 8'd15) ? 4'd15 : value[3:0];
    assign bright_round = ssp_pkg::level_round(bright_clamp);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        ssp_pkg::OP_TEXT_CHAR:
                        begin
                            if (!value[7] && pos_reg < ssp_pkg::TEXT_POS_MAX)
                            begin
                                state_next = ssp_pkg::ST_LOOKUP;
                            end
                        end
                        ssp_pkg::OP_TEXT_END, ssp_pkg::OP_DIGIT, ssp_pkg::OP_DOTS:
                        begin
                            state_next = ssp_pkg::ST_DISP;
                        end
                        ssp_pkg::OP_LED:
                        begin
                            if (index < 7'd2)
                            begin
                                state_next = ssp_pkg::ST_LED;
                            end
                        end
                        ssp_pkg::OP_BRIGHTNESS, ssp_pkg::OP_RAW:
                        begin
                            state_next = ssp_pkg::ST_ONE;
                        end
                        default:
                        begin
                            state_next = ssp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ssp_pkg::ST_LOOKUP:
            begin
                state_next = ssp_pkg::ST_IDLE;
            end
            ssp_pkg::ST_DISP:
            begin
                if (out_free && cnt_reg == ssp_pkg::DISP_LAST)
                begin
                    state_next = ssp_pkg::ST_IDLE;
                end
            end
            ssp_pkg::ST_LED:
            begin
                if (out_free && cnt_reg == ssp_pkg::LED_LAST)
                begin
                    state_next = ssp_pkg::ST_IDLE;
                end
            end
            ssp_pkg::ST_ONE:
            begin
                if (out_free)
                begin
                    state_next = ssp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssp_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_tready  = 1'b0;
        load      = 1'b0;
        load_byte = 8'h00;
        load_last = 1'b0;
        case (state_reg)
            ssp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ssp_pkg::ST_DISP:
            begin
                load      = out_free;
                load_byte = disp_byte;
                load_last = (cnt_reg == ssp_pkg::DISP_LAST);
            end
            ssp_pkg::ST_LED:
            begin
                load      = out_free;
                load_byte = (cnt_reg == 3'd0) ? ssp_pkg::LED_CMD : led_byte;
                load_last = (cnt_reg == ssp_pkg::LED_LAST);
            end
            ssp_pkg::ST_ONE:
            begin
                load      = out_free;
                load_byte = one_byte_reg;
                load_last = one_last_reg;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Panel state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ssp_pkg::NUM_DIGITS; i++)
            begin
                digit_reg[i] <= 8'hFF;
            end
            dot_reg      <= 4'd0;
            led_reg      <= 2'd0;
            bright_reg   <= 4'd0;
            pos_reg      <= 3'd0;
            lwd_reg      <= 1'b1;
            one_byte_reg <= 8'h00;
            one_last_reg <= 1'b0;
        end
        else if (accept)
        begin
            case (op)
                ssp_pkg::OP_TEXT_START:
                begin
                    for (int i = 0; i < ssp_pkg::NUM_DIGITS; i++)
                    begin
                        digit_reg[i] <= 8'h00;
                    end
                    if (!upside_down)
                    begin
                        dot_reg <= 4'd0;
                    end
                    pos_reg <= 3'd0;
                    lwd_reg <= 1'b1;
                end
                ssp_pkg::OP_DIGIT:
                begin
                    if (index < 7'd4)
                    begin
                        digit_reg[index[1:0]] <= value;
                    end
                end
                ssp_pkg::OP_DOTS:
                begin
                    dot_reg <= value[3:0];
                end
                ssp_pkg::OP_LED:
                begin
                    if (index < 7'd2)
                    begin
                        led_reg[index[0]] <= (value != 8'd0);
                    end
                end
                ssp_pkg::OP_BRIGHTNESS:
                begin
                    bright_reg   <= bright_round;
                    one_byte_reg <= ssp_pkg::level_cmd(bright_round);
                    one_last_reg <= 1'b1;
                end
                ssp_pkg::OP_RAW:
                begin
                    one_byte_reg <= value;
                    one_last_reg <= last;
                end
                default:
                begin
                    one_last_reg <= one_last_reg;
                end
            endcase
        end
        else if (state_reg == ssp_pkg::ST_LOOKUP)
        begin
            // Merge the mapped symbol into the digits or the dots
            if (is_dot)
            begin
                lwd_reg <= 1'b1;
                if (dot_pos < 3'd4)
                begin
                    dot_reg[dot_pos[1:0]] <= 1'b1;
                end
                pos_reg <= dot_pos + 3'd1;
            end
            else
            begin
                if (pos_reg < 3'd4)
                begin
                    lwd_reg                 <= 1'b0;
                    digit_reg[pos_reg[1:0]] <= map_data;
                end
                pos_reg <= pos_reg + 3'd1;
            end
        end
    end

    // Frame slot counter and output byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 3'd0;
            valid_reg <= 1'b0;
            byte_reg  <= 8'h00;
            end_reg   <= 1'b0;
            level_reg <= 4'd0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= 3'd0;
            end
            else if (load)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end

            if (load)
            begin
                valid_reg <= 1'b1;
                byte_reg  <= load_byte;
                end_reg   <= load_last;
                level_reg <= bright_reg;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid  = valid_reg;
    assign out_byte  = byte_reg;
    assign frame_end = end_reg;
    assign level_now = level_reg;

    assign status = '{state: state_reg, text_pos: pos_reg, cnt: cnt_reg, load: load};

endmodule

// ===== tb/tb_seven_segment_panel_formatter.sv =====
// Self-checking testbench for seven_segment_panel_formatter: directed table, then random
// request traffic under three flow-control mixes, compared byte by byte with a local predictor.
// Depends on ssp_pkg and the formatter RTL only.
module tb_seven_segment_panel_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    // Spare opcodes that the block drops
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    localparam logic [7:0] DOT_SEG      = 8'h80;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         DRAIN_CYCLES  = 20;
    localparam int         RANDOM_QUOTA  = 160;

    // Clamped brightness to supported level, and level to command byte
    localparam logic [3:0] LEVEL_STEP [16] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd14};
    localparam logic [7:0] LEVEL_CODE [16] = '{8'h80, 8'h88, 8'h89, 8'hC0, 8'h8A, 8'hC0,
        8'hC0, 8'hC0, 8'hC0, 8'hC0, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h00};

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [3:0] op;
        logic [6:0] idx;
        logic [7:0] val;       // setting in bit 0 for ROW_CFG
        logic       lst;
        logic       typed;     // final byte of the request is given below
        logic [7:0] typed_byte;
    } panel_row_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fe;
        logic [3:0] lvl;
    } panel_byte_t;

    // Directed script
    localparam panel_row_t SCRIPT [30] = '{
        '{ROW_CFG, ssp_pkg::OP_MAP_WRITE,  7'd0,   8'h00, 1'b0, 1'b0, 8'h00},
        // display right after reset: every segment lit, with no dots
        '{ROW_REQ, ssp_pkg::OP_TEXT_END,   7'd0,   8'h00, 1'b0, 1'b1, 8'h7F},
        '{ROW_REQ, ssp_pkg::OP_RAW,        7'd0,   8'h00, 1'b0, 1'b1, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_RAW,        7'd127, 8'hFF, 1'b1, 1'b1, 8'hFF},
        // brightness clamped to 15, then rounded
        '{ROW_REQ, ssp_pkg::OP_BRIGHTNESS, 7'd0,   8'hFF, 1'b0, 1'b1, 8'h8F},
        '{ROW_REQ, ssp_pkg::OP_BRIGHTNESS, 7'd0,   8'h03, 1'b0, 1'b1, 8'h8A},
        '{ROW_REQ, ssp_pkg::OP_MAP_WRITE,  7'd0,   8'h3F, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_MAP_WRITE,  7'd127, 8'h80, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_MAP_WRITE,  7'd85,  8'h7F, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_TEXT_START, 7'd0,   8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_TEXT_CHAR,  7'd0,   8'h00, 1'b0, 1'b0, 8'h00},
        // character outside the map is skipped
        '{ROW_REQ, ssp_pkg::OP_TEXT_CHAR,  7'd0,   8'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_TEXT_CHAR,  7'd0,   8'd85, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_TEXT_CHAR,  7'd0,   8'd85, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_TEXT_CHAR,  7'd0,   8'd85, 1'b0, 1'b0, 8'h00},
        // dot folds back onto the last digit, a second one lands past the panel
        '{ROW_REQ, ssp_pkg::OP_TEXT_CHAR,  7'd0,   8'd127, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_TEXT_CHAR,  7'd0,   8'd127, 1'b0, 1'b0, 8'h00},
        // text full: ignored
        '{ROW_REQ, ssp_pkg::OP_TEXT_CHAR,  7'd0,   8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_TEXT_END,   7'd0,   8'h00, 1'b0, 1'b0, 8'h00},
        // digit index out of range still sends a frame
        '{ROW_REQ, ssp_pkg::OP_DIGIT,      7'd127, 8'h55, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_DIGIT,      7'd2,   8'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_DOTS,       7'd0,   8'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_LED,        7'd0,   8'h01, 1'b0, 1'b1, 8'h02},
        '{ROW_REQ, ssp_pkg::OP_LED,        7'd1,   8'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_LED,        7'd127, 8'h01, 1'b1, 1'b0, 8'h00},
        '{ROW_REQ, OP_UNUSED_HI,           7'd127, 8'hFF, 1'b1, 1'b0, 8'h00},
        // rotated panel: dots survive text start, the mark is an ordinary segment byte
        '{ROW_CFG, ssp_pkg::OP_MAP_WRITE,  7'd0,   8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_TEXT_START, 7'd0,   8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_TEXT_CHAR,  7'd0,   8'd127, 1'b0, 1'b0, 8'h00},
        '{ROW_REQ, ssp_pkg::OP_TEXT_END,   7'd0,   8'h00, 1'b0, 1'b0, 8'h00}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Panel state as the predictor sees it
    logic [7:0]  shown_digits [ssp_pkg::NUM_DIGITS];
    logic [3:0]  dot_mask;
    logic [1:0]  led_mask;
    logic [3:0]  level;
    logic [7:0]  char_map [128];
    bit          map_written [128];
    logic [2:0]  text_pos;
    logic        after_dot;
    logic        panel_flipped;
    int          mapped_chars [$];

    panel_byte_t frame_bytes_due [$];

    int src_idle_pct;
    int stall_pct;
    int errors;
    int requests_sent;
    int bytes_checked;

    seven_segment_panel_formatter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fe);
        frame_bytes_due.push_back('{b: b, fe: fe, lvl: level});
    endtask

    function automatic logic [7:0] flip_segments(input logic [7:0] s);
        return ((s & 8'h07) << 3) | ((s >> 3) & 8'h07) | (s & 8'h40);
    endfunction

    // Build the eight-byte display frame from the current digits and dots
    task automatic queue_display();
        logic [7:0] frame [8];
        logic [7:0] seg;
        for (int i = 0; i < 8; i++)
            frame[i] = 8'h00;
        frame[0] = ssp_pkg::ADDR_CMD;
        for (int i = 0; i < ssp_pkg::NUM_DIGITS; i++)
        begin
            seg = panel_flipped ? flip_segments(shown_digits[i])
                                : (shown_digits[i] & ssp_pkg::SEG_MASK);
            if (dot_mask[i])
                seg = seg | DOT_SEG;
            if (panel_flipped)
                frame[1 + 2 * i] = seg;
            else
                frame[7 - 2 * i] = seg;
        end
        for (int i = 0; i < 8; i++)
            queue_byte(frame[i], i == 7);
    endtask

    task automatic queue_leds();
        logic [1:0] bits;
        bits = panel_flipped ? led_mask : {led_mask[0], led_mask[1]};
        queue_byte(ssp_pkg::LED_CMD, 1'b0);
        queue_byte({6'b0, bits}, 1'b1);
    endtask

    // Place one text character: digit, folded dot, or nothing
    task automatic place_char(input logic [7:0] c);
        logic [7:0] sym;
        if (text_pos >= ssp_pkg::TEXT_POS_MAX || c[7])
            return;
        sym = char_map[c[6:0]];
        if (!panel_flipped && sym[7])
        begin
            if (!after_dot && text_pos > 0)
                text_pos = text_pos - 3'd1;
            after_dot = 1'b1;
            if (text_pos < ssp_pkg::NUM_DIGITS)
                dot_mask[text_pos[1:0]] = 1'b1;
        end
        else if (text_pos < ssp_pkg::NUM_DIGITS)
        begin
            after_dot = 1'b0;
            shown_digits[text_pos[1:0]] = sym;
        end
        text_pos = text_pos + 3'd1;
    endtask

    // Advance the predicted panel by one accepted request and queue its bytes
    task automatic advance_panel(input logic [3:0] op, input logic [6:0] idx,
                                 input logic [7:0] val, input logic lst);
        case (op)
            ssp_pkg::OP_MAP_WRITE:
            begin
                char_map[idx] = val;
                if (!map_written[idx])
                begin
                    map_written[idx] = 1'b1;
                    mapped_chars.push_back(idx);
                end
            end
            ssp_pkg::OP_TEXT_START:
            begin
                for (int i = 0; i < ssp_pkg::NUM_DIGITS; i++)
                    shown_digits[i] = 8'h00;
                if (!panel_flipped)
                    dot_mask = 4'h0;
                text_pos = 3'd0;
                after_dot = 1'b1;
            end
            ssp_pkg::OP_TEXT_CHAR:
                place_char(val);
            ssp_pkg::OP_TEXT_END:
                queue_display();
            ssp_pkg::OP_DIGIT:
            begin
                if (idx < ssp_pkg::NUM_DIGITS)
                    shown_digits[idx[1:0]] = val;
                queue_display();
            end
            ssp_pkg::OP_DOTS:
            begin
                dot_mask = val[3:0];
                queue_display();
            end
            ssp_pkg::OP_LED:
            begin
                if (idx <= 7'd1)
                begin
                    led_mask[idx[0]] = (val != 8'h00);
                    queue_leds();
                end
            end
            ssp_pkg::OP_BRIGHTNESS:
            begin
                level = LEVEL_STEP[(val > 8'd15) ? 4'd15 : val[3:0]];
                queue_byte(LEVEL_CODE[level], 1'b1);
            end
            ssp_pkg::OP_RAW:
                queue_byte(val, lst);
            default:
                ;
        endcase
    endtask

    // Offer one request, hold it until taken, then predict
    task automatic send_request(input logic [3:0] op, input logic [6:0] idx,
                                input logic [7:0] val, input logic lst);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, val, idx, op};
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        advance_panel(op, idx, val, lst);
        requests_sent++;
    endtask

    // Drop valid and wait until every byte is out and the core has gone quiet
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_orientation(input logic flipped);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= flipped;
        @(posedge clk);
        cfg_we <= 1'b0;
        panel_flipped = flipped;
    endtask

    function automatic logic [7:0] pick_char();
        if (mapped_chars.size() == 0 || $urandom_range(99) < 12)
            return 8'h80 | 8'($urandom_range(127));
        return 8'(mapped_chars[$urandom_range(mapped_chars.size() - 1)]);
    endfunction

    // Random traffic, mostly whole text sequences and well-formed updates
    task automatic run_random(input int quota);
        int counted;
        int pick;
        int n;
        logic [7:0] v;
        counted = 0;
        while (counted < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 18)
            begin
                n = $urandom_range(7, 1);
                send_request(ssp_pkg::OP_TEXT_START, 7'($urandom_range(127)),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
                for (int k = 0; k < n; k++)
                    send_request(ssp_pkg::OP_TEXT_CHAR, 7'($urandom_range(127)), pick_char(),
                                 1'($urandom_range(1)));
                counted += n + 1;
                // leave some sequences unterminated
                if ($urandom_range(99) < 85)
                begin
                    send_request(ssp_pkg::OP_TEXT_END, 7'($urandom_range(127)),
                                 8'($urandom_range(255)), 1'($urandom_range(1)));
                    counted++;
                end
            end
            else if (pick < 95)
            begin
                v = 8'($urandom_range(255));
                if (pick < 28)
                begin
                    if ($urandom_range(99) < 70)
                        v[7] = 1'b0;
                    send_request(ssp_pkg::OP_MAP_WRITE, 7'($urandom_range(127)), v,
                                 1'($urandom_range(1)));
                end
                else if (pick < 42)
                    send_request(ssp_pkg::OP_DIGIT,
                                 ($urandom_range(99) < 80) ? 7'($urandom_range(3))
                                 : 7'($urandom_range(127)), v, 1'($urandom_range(1)));
                else if (pick < 50)
                    send_request(ssp_pkg::OP_DOTS, 7'($urandom_range(127)), v,
                                 1'($urandom_range(1)));
                else if (pick < 62)
                    send_request(ssp_pkg::OP_LED,
                                 ($urandom_range(99) < 80) ? 7'($urandom_range(1))
                                 : 7'($urandom_range(127)), v, 1'($urandom_range(1)));
                else if (pick < 74)
                    send_request(ssp_pkg::OP_BRIGHTNESS, 7'($urandom_range(127)),
                                 ($urandom_range(1) != 0) ? 8'($urandom_range(20)) : v,
                                 1'($urandom_range(1)));
                else
                    send_request(ssp_pkg::OP_RAW, 7'($urandom_range(127)), v,
                                 1'($urandom_range(1)));
                counted++;
            end
            else if (pick < 97)
                send_request(4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)),
                             7'($urandom_range(127)), 8'($urandom_range(255)),
                             1'($urandom_range(1)));
            else
            begin
                // stray text request out of sequence
                n = $urandom_range(2);
                send_request((n == 0) ? ssp_pkg::OP_TEXT_START :
                             (n == 1) ? ssp_pkg::OP_TEXT_CHAR : ssp_pkg::OP_TEXT_END,
                             7'($urandom_range(127)), pick_char(), 1'($urandom_range(1)));
                counted++;
            end
        end
    endtask

    // Output side: check each taken byte, then pick the next ready
    always @(posedge clk)
    begin : byte_sink
        panel_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_bytes_due.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", m_tdata[7:0]));
            else
            begin
                want = frame_bytes_due.pop_front();
                bytes_checked++;
                if (m_tdata[7:0] !== want.b)
                    report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                              m_tdata[7:0], want.b));
                if (m_tlast !== want.fe)
                    report_mismatch($sformatf("frame_end %0b, predicted %0b (byte %02h)",
                                              m_tlast, want.fe, want.b));
                if (m_tdata[11:8] !== want.lvl)
                    report_mismatch($sformatf("level_now %0d, predicted %0d (byte %02h)",
                                              m_tdata[11:8], want.lvl, want.b));
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop if the block hangs
    initial
    begin
        #5_000_000;
        $display("seven_segment_panel_formatter: mismatch");
        $finish;
    end

    initial
    begin
        errors        = 0;
        requests_sent = 0;
        bytes_checked = 0;
        src_idle_pct  = 11;
        stall_pct     = 69;
        panel_flipped = 1'b0;
        for (int i = 0; i < ssp_pkg::NUM_DIGITS; i++)
            shown_digits[i] = 8'hFF;
        dot_mask  = 4'h0;
        led_mask  = 2'b00;
        level     = 4'd0;
        text_pos  = 3'd0;
        after_dot = 1'b1;
        for (int i = 0; i < 128; i++)
        begin
            char_map[i]    = 8'h00;
            map_written[i] = 1'b0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed script
        for (int r = 0; r < $size(SCRIPT); r++)
        begin
            if (SCRIPT[r].kind == ROW_CFG)
                set_orientation(SCRIPT[r].val[0]);
            else
            begin
                send_request(SCRIPT[r].op, SCRIPT[r].idx, SCRIPT[r].val, SCRIPT[r].lst);
                if (SCRIPT[r].typed)
                    frame_bytes_due[frame_bytes_due.size() - 1].b = SCRIPT[r].typed_byte;
            end
        end

        // Slow sink, then slow source, then full rate
        set_orientation(1'b0);
        run_random(RANDOM_QUOTA);
        set_orientation(1'b1);
        src_idle_pct = 69;
        stall_pct    = 11;
        run_random(RANDOM_QUOTA);
        set_orientation(1'b0);
        src_idle_pct = 0;
        stall_pct    = 0;
        run_random(RANDOM_QUOTA);

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests across both panel orientations and three flow-control mixes,",
                 requests_sent);
        $display("checked %0d output bytes, %0d errors.", bytes_checked, errors);
        if (errors == 0)
            $display("seven_segment_panel_formatter: match");
        else
            $display("seven_segment_panel_formatter: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ssp_pkg.sv
rtl/core/ssp_ram.sv
rtl/core/ssp_core.sv
rtl/core/seven_segment_panel_formatter.sv
tb/tb_seven_segment_panel_formatter.sv
